FILE: rtl/trdf_pkg.sv
package trdf_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_POS     = 2'd0,
      KIND_UP      = 2'd1,
      KIND_KEYDOWN = 2'd2,
      KIND_KEYUP   = 2'd3
   } kind_type;

   // request kinds
   typedef enum logic {
      REQ_REPORT = 1'b0,
      REQ_TICK   = 1'b1
   } req_kind_type;

   // key currently held down
   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_MENU = 2'd1,
      HELD_BACK = 2'd2
   } held_type;

   localparam logic KEYID_MENU = 1'b0;
   localparam logic KEYID_BACK = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_DEAD_X      = 3'd0;
   localparam logic [2:0] CSR_DEAD_Y      = 3'd1;
   localparam logic [2:0] CSR_SPAN_X      = 3'd2;
   localparam logic [2:0] CSR_SPAN_Y      = 3'd3;
   localparam logic [2:0] CSR_PENUP_TICKS = 3'd4;

   localparam logic [7:0]  DEAD_X_RST      = 8'd15;
   localparam logic [7:0]  DEAD_Y_RST      = 8'd15;
   localparam logic [11:0] SPAN_X_RST      = 12'd1814;
   localparam logic [11:0] SPAN_Y_RST      = 12'd3024;
   localparam logic [15:0] PENUP_TICKS_RST = 16'd100;

   // floor(v / 3) == (v * 2731) >> 13 for any 12-bit v
   localparam logic [11:0] DIV3_MUL   = 12'd2731;
   localparam int          DIV3_SHIFT = 13;

   typedef struct packed {
      logic [7:0]  dead_x;
      logic [7:0]  dead_y;
      logic [11:0] span_x;
      logic [11:0] span_y;
      logic [15:0] penup_ticks;
   } cfg_type;

endpackage

FILE: rtl/trdf_csr.sv
module trdf_csr
   import trdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [2:0]  wr_index,
   input  logic [15:0] wr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_x      <= DEAD_X_RST;
         cfg_ff.dead_y      <= DEAD_Y_RST;
         cfg_ff.span_x      <= SPAN_X_RST;
         cfg_ff.span_y      <= SPAN_Y_RST;
         cfg_ff.penup_ticks <= PENUP_TICKS_RST;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_DEAD_X:      cfg_ff.dead_x      <= wr_data[7:0];
            CSR_DEAD_Y:      cfg_ff.dead_y      <= wr_data[7:0];
            CSR_SPAN_X:      cfg_ff.span_x      <= wr_data[11:0];
            CSR_SPAN_Y:      cfg_ff.span_y      <= wr_data[11:0];
            CSR_PENUP_TICKS: cfg_ff.penup_ticks <= wr_data;
            default: ;  // unknown index, dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/trdf_coord.sv
module trdf_coord
   import trdf_pkg::*;
(
   input  logic [7:0]  x_high,
   input  logic [7:0]  y_high,
   input  logic [7:0]  xy_low,
   input  logic [11:0] span_x,
   input  logic [11:0] span_y,
   output logic [10:0] pos_x,
   output logic [10:0] pos_y
);

   logic [11:0] raw_x;
   logic [11:0] raw_y;
   logic [11:0] mir_x;
   logic [11:0] mir_y;
   logic [23:0] prod_y;

   assign raw_x = {x_high, xy_low[3:0]};
   assign raw_y = {y_high, xy_low[7:4]};

   // mirror; a raw value past the span pins to zero
   assign mir_x = (raw_x > span_x) ? 12'd0 : span_x - raw_x;
   assign mir_y = (raw_y > span_y) ? 12'd0 : span_y - raw_y;

   assign pos_x  = mir_x[11:1];
   assign prod_y = mir_y * DIV3_MUL;
   assign pos_y  = prod_y[DIV3_SHIFT +: 11];

endmodule

FILE: rtl/touch_report_deadband_filter.sv
// Touch report deadband filter. Each request is a controller report
// (req_tuser = 0) or a timer tick (req_tuser = 1) and yields zero or one
// result: a position with the finger down, a touch release, a key press or a
// key release. Key handling takes precedence over finger data; a finger
// report only yields a position on the first point of a touch or when it
// moves at least the deadband on one axis from the last reported point.
// Finger reports re-arm a pen-up countdown of penup_ticks ticks; on expiry a
// release is sent. One request is taken per clock while the result slot is
// free: a request waits in the input register, is decoded against the filter
// state in a single pass and, if it yields a result, lands in the result
// register, which drives rsp_tvalid. Only a stalled result (rsp_tready low)
// holds the input side.
// Configuration writes are taken in every cycle and must be issued only while
// no request is in flight.
module touch_report_deadband_filter
   import trdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // key_status, finger_state, x_high, y_high, xy_low
   input  logic        req_tuser,   // req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pos_x, pos_y, key_id, zero pad
   output logic [1:0]  rsp_tuser,   // event_kind
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg;

   // input register
   logic         in_vld_ff;
   req_kind_type in_kind_ff;
   logic [39:0]  in_data_ff;

   // filter state
   held_type    held_ff,     held_in;
   logic        touching_ff, touching_in;
   logic        armed_ff,    armed_in;
   logic [15:0] ticks_ff,    ticks_in;
   logic [10:0] ref_x_ff,    ref_x_in;
   logic [10:0] ref_y_ff,    ref_y_in;

   // result register
   logic        out_vld_ff,  out_vld_in;
   kind_type    out_kind_ff, out_kind_in;
   logic [10:0] out_x_ff,    out_x_in;
   logic [10:0] out_y_ff,    out_y_in;
   logic        out_key_ff,  out_key_in;

   logic        out_free;
   logic        advance;
   logic [7:0]  key_status;
   logic [7:0]  finger_state;
   logic [10:0] pos_x;
   logic [10:0] pos_y;
   logic [10:0] diff_x;
   logic [10:0] diff_y;
   logic        still;

   assign csr_ready = 1'b1;

   trdf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign key_status   = in_data_ff[7:0];
   assign finger_state = in_data_ff[15:8];

   trdf_coord u_coord (
      .x_high (in_data_ff[23:16]),
      .y_high (in_data_ff[31:24]),
      .xy_low (in_data_ff[39:32]),
      .span_x (cfg.span_x),
      .span_y (cfg.span_y),
      .pos_x  (pos_x),
      .pos_y  (pos_y)
   );

   // handshake: the held request moves on once the result slot is free
   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   assign diff_x = (pos_x >= ref_x_ff) ? pos_x - ref_x_ff : ref_x_ff - pos_x;
   assign diff_y = (pos_y >= ref_y_ff) ? pos_y - ref_y_ff : ref_y_ff - pos_y;
   // inside the deadband on both axes
   assign still  = (diff_x < {3'd0, cfg.dead_x}) && (diff_y < {3'd0, cfg.dead_y});

   always_comb begin
      held_in     = held_ff;
      touching_in = touching_ff;
      armed_in    = armed_ff;
      ticks_in    = ticks_ff;
      ref_x_in    = ref_x_ff;
      ref_y_in    = ref_y_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_key_in  = out_key_ff;

      if (advance) begin
         out_kind_in = KIND_POS;
         out_x_in    = 11'd0;
         out_y_in    = 11'd0;
         out_key_in  = KEYID_MENU;
         if (in_kind_ff == REQ_TICK) begin
            if (armed_ff) begin
               if (ticks_ff > 16'd1) begin
                  ticks_in = ticks_ff - 16'd1;
               end else begin
                  // pen-up timeout
                  ticks_in    = 16'd0;
                  armed_in    = 1'b0;
                  touching_in = 1'b0;
                  out_vld_in  = 1'b1;
                  out_kind_in = KIND_UP;
               end
            end
         end else begin
            priority if (held_ff != HELD_NONE && key_status == 8'd0) begin
               held_in     = HELD_NONE;
               out_vld_in  = 1'b1;
               out_kind_in = KIND_KEYUP;
               out_key_in  = (held_ff == HELD_BACK) ? KEYID_BACK : KEYID_MENU;
            end else if (key_status[1]) begin
               held_in     = HELD_MENU;
               out_vld_in  = 1'b1;
               out_kind_in = KIND_KEYDOWN;
               out_key_in  = KEYID_MENU;
            end else if (key_status[0]) begin
               held_in     = HELD_BACK;
               out_vld_in  = 1'b1;
               out_kind_in = KIND_KEYDOWN;
               out_key_in  = KEYID_BACK;
            end else if (finger_state != 8'd0) begin
               armed_in = 1'b1;
               ticks_in = cfg.penup_ticks;
               // first point of a touch always goes out
               if (!touching_ff || !still) begin
                  touching_in = 1'b1;
                  ref_x_in    = pos_x;
                  ref_y_in    = pos_y;
                  out_vld_in  = 1'b1;
                  out_x_in    = pos_x;
                  out_y_in    = pos_y;
               end
            end else begin
               // no key change and no finger data
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         held_ff     <= HELD_NONE;
         touching_ff <= 1'b0;
         armed_ff    <= 1'b0;
         ticks_ff    <= 16'd0;
         ref_x_ff    <= 11'd0;
         ref_y_ff    <= 11'd0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         out_vld_ff  <= out_vld_in;
         held_ff     <= held_in;
         touching_ff <= touching_in;
         armed_ff    <= armed_in;
         ticks_ff    <= ticks_in;
         ref_x_ff    <= ref_x_in;
         ref_y_ff    <= ref_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_kind_type'(req_tuser);
         in_data_ff <= req_tdata;
      end
      out_kind_ff <= out_kind_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_key_ff  <= out_key_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {1'b0, out_key_ff, out_y_ff, out_x_ff};

   // the countdown runs exactly while a touch is active
   a_armed_touch: assert property (@(posedge clock) disable iff (reset)
      armed_ff == touching_ff)
      else $error("pen-up timer and touch state disagree");

   // a pending position result always belongs to an active touch
   a_pos_touch: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_kind_ff == KIND_POS) |-> touching_ff)
      else $error("position result without an active touch");

   // expiring tick ends the touch and reports a release
   a_expiry: assert property (@(posedge clock) disable iff (reset)
      (advance && in_kind_ff == REQ_TICK && armed_ff && ticks_ff <= 16'd1)
      |=> (!touching_ff && out_vld_ff && out_kind_ff == KIND_UP))
      else $error("pen-up expiry mishandled");

   // state frozen while a result is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready) |=> ($stable(held_ff) && $stable(ticks_ff)
                                       && $stable(ref_x_ff) && $stable(ref_y_ff)))
      else $error("filter state moved under a stalled result");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

import trdf_pkg::*;

// Predicts the events of the deadband filter and checks what the block sends.
class touch_event_predictor;

   typedef struct {
      kind_type    kind;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
      logic        key_id;
   } touch_event_type;

   cfg_type         cfg;
   held_type        held;
   bit              touching;
   int              anchor_x;
   int              anchor_y;
   bit              armed;
   int unsigned     countdown;
   touch_event_type expected_events[$];
   int              failures;

   function new();
      cfg.dead_x      = DEAD_X_RST;
      cfg.dead_y      = DEAD_Y_RST;
      cfg.span_x      = SPAN_X_RST;
      cfg.span_y      = SPAN_Y_RST;
      cfg.penup_ticks = PENUP_TICKS_RST;
      held      = HELD_NONE;
      touching  = 1'b0;
      anchor_x  = 0;
      anchor_y  = 0;
      armed     = 1'b0;
      countdown = 0;
      failures  = 0;
   endfunction

   function void write_register(logic [2:0] index, logic [15:0] value);
      case (index)
         CSR_DEAD_X:      cfg.dead_x      = value[7:0];
         CSR_DEAD_Y:      cfg.dead_y      = value[7:0];
         CSR_SPAN_X:      cfg.span_x      = value[11:0];
         CSR_SPAN_Y:      cfg.span_y      = value[11:0];
         CSR_PENUP_TICKS: cfg.penup_ticks = value;
         default: ;
      endcase
   endfunction

   function void push_event(kind_type kind, int px, int py, logic key);
      touch_event_type ev;
      ev.kind   = kind;
      ev.pos_x  = px[10:0];
      ev.pos_y  = py[10:0];
      ev.key_id = key;
      expected_events.push_back(ev);
   endfunction

   function int pending();
      return expected_events.size();
   endfunction

   // one accepted request; pushes the event it causes, if any
   function void note_request(req_kind_type kind, logic [7:0] keys, logic [7:0] finger,
                              logic [7:0] x_high, logic [7:0] y_high, logic [7:0] xy_low);
      int raw_x;
      int raw_y;
      int span_x;
      int span_y;
      int px;
      int py;
      int dx;
      int dy;
      if (kind == REQ_TICK) begin
         if (!armed)
            return;
         if (countdown > 1) begin
            countdown--;
            return;
         end
         countdown = 0;
         armed     = 1'b0;
         touching  = 1'b0;
         push_event(KIND_UP, 0, 0, KEYID_MENU);
         return;
      end
      // key handling wins over finger data
      if (held != HELD_NONE && keys == 8'd0) begin
         push_event(KIND_KEYUP, 0, 0, (held == HELD_BACK) ? KEYID_BACK : KEYID_MENU);
         held = HELD_NONE;
         return;
      end
      if (keys[1]) begin
         held = HELD_MENU;
         push_event(KIND_KEYDOWN, 0, 0, KEYID_MENU);
         return;
      end
      if (keys[0]) begin
         held = HELD_BACK;
         push_event(KIND_KEYDOWN, 0, 0, KEYID_BACK);
         return;
      end
      if (finger == 8'd0)
         return;
      raw_x  = int'({x_high, xy_low[3:0]});
      raw_y  = int'({y_high, xy_low[7:4]});
      span_x = int'(cfg.span_x);
      span_y = int'(cfg.span_y);
      px = (raw_x > span_x) ? 0 : (span_x - raw_x) / 2;
      py = (raw_y > span_y) ? 0 : (span_y - raw_y) / 3;
      armed     = 1'b1;
      countdown = cfg.penup_ticks;
      dx = (px > anchor_x) ? px - anchor_x : anchor_x - px;
      dy = (py > anchor_y) ? py - anchor_y : anchor_y - py;
      if (touching && dx < int'(cfg.dead_x) && dy < int'(cfg.dead_y))
         return;
      touching = 1'b1;
      anchor_x = px;
      anchor_y = py;
      push_event(KIND_POS, px, py, KEYID_MENU);
   endfunction

   function void check_event(kind_type kind, logic [10:0] pos_x, logic [10:0] pos_y,
                             logic key_id);
      touch_event_type ev;
      if (expected_events.size() == 0) begin
         $error("unexpected event: event_kind %0d pos_x %0d pos_y %0d key_id %0d",
                kind, pos_x, pos_y, key_id);
         failures++;
         return;
      end
      ev = expected_events.pop_front();
      if (kind !== ev.kind) begin
         $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
         failures++;
      end
      if (pos_x !== ev.pos_x) begin
         $error("pos_x: expected %0d, actual %0d", ev.pos_x, pos_x);
         failures++;
      end
      if (pos_y !== ev.pos_y) begin
         $error("pos_y: expected %0d, actual %0d", ev.pos_y, pos_y);
         failures++;
      end
      if (key_id !== ev.key_id) begin
         $error("key_id: expected %0d, actual %0d", ev.key_id, key_id);
         failures++;
      end
   endfunction
endclass

module testbench;
   import trdf_pkg::*;

   localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 4;     // input and result registers plus margin
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // key_status, finger_state, x_high, y_high, xy_low
   logic        req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // pos_x, pos_y, key_id, zero pad
   logic [1:0]  rsp_tuser;   // event_kind
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   // no random gaps on either side while set
   bit steady = 1'b0;

   // last raw coordinates of the random touch track
   int track_x;
   int track_y;
   int stall_cycles = 0;

   touch_event_predictor predictor = new();

   touch_report_deadband_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side backpressure: rsp_tready low with a chance of 13 in a hundred, never while steady
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 13);
   end

   // sample handshakes at the rising edge; inputs move only on the falling edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            predictor.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            predictor.note_request(req_kind_type'(req_tuser), req_tdata[7:0],
                                   req_tdata[15:8], req_tdata[23:16],
                                   req_tdata[31:24], req_tdata[39:32]);
         if (rsp_tvalid && rsp_tready)
            predictor.check_event(kind_type'(rsp_tuser), rsp_tdata[10:0],
                                  rsp_tdata[21:11], rsp_tdata[22]);
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one request; random idle cycles ahead of it, then wait for acceptance
   task automatic send_request(req_kind_type kind, logic [7:0] keys, logic [7:0] finger,
                               logic [11:0] raw_x, logic [11:0] raw_y);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {raw_y[3:0], raw_x[3:0], raw_y[11:4], raw_x[11:4], finger, keys};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic end_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every pending event, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (predictor.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // extremes often, typical values otherwise
   function automatic logic [15:0] pick_value(int unsigned top, int unsigned typ_low,
                                              int unsigned typ_high);
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return top[15:0];
         2:       return 16'($urandom_range(top));
         default: return 16'($urandom_range(typ_high, typ_low));
      endcase
   endfunction

   // new settings for a random phase; junk above each register's width is masked
   task automatic program_phase();
      logic [15:0] junk;
      logic [15:0] v;
      junk = 16'($urandom);
      v = pick_value(255, 1, 30);
      write_csr(CSR_DEAD_X, {junk[7:0], v[7:0]});
      junk = 16'($urandom);
      v = pick_value(255, 1, 30);
      write_csr(CSR_DEAD_Y, {junk[7:0], v[7:0]});
      junk = 16'($urandom);
      v = pick_value(4095, 1200, 4095);
      write_csr(CSR_SPAN_X, {junk[3:0], v[11:0]});
      junk = 16'($urandom);
      v = pick_value(4095, 1200, 4095);
      write_csr(CSR_SPAN_Y, {junk[3:0], v[11:0]});
      write_csr(CSR_PENUP_TICKS, pick_value(65535, 1, 10));
      // indexes past the last register must be ignored
      if ($urandom_range(2) == 0)
         write_csr(CSR_PENUP_TICKS + 3'd1 + 3'($urandom_range(2)), 16'($urandom));
      end_csr();
   endtask

   function automatic int clamp_raw(int v);
      if (v < 0)
         return 0;
      if (v > 4095)
         return 4095;
      return v;
   endfunction

   // mostly touch tracks jittering around the deadband, plus tick bursts,
   // key traffic and plain noise
   task automatic run_phase(int count);
      int          sent;
      int          roll;
      int          burst;
      int          reach_x;
      int          reach_y;
      logic [7:0]  keys;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < 22) begin
            burst = $urandom_range(8, 1);
            repeat (burst) begin
               send_request(REQ_TICK, 8'($urandom), 8'($urandom), 12'($urandom),
                            12'($urandom));
               sent++;
            end
         end else if (roll < 32) begin
            keys = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
            send_request(REQ_REPORT, keys, 8'($urandom), 12'($urandom), 12'($urandom));
            sent++;
         end else if (roll < 42) begin
            send_request(req_kind_type'($urandom_range(1)), 8'($urandom), 8'($urandom),
                         12'($urandom), 12'($urandom));
            sent++;
         end else begin
            if ($urandom_range(3) == 0) begin
               track_x = $urandom_range(4095);
               track_y = $urandom_range(4095);
            end else begin
               // raw steps span a little over twice the deadband after the divide
               reach_x = 4 * int'(predictor.cfg.dead_x) + 4;
               reach_y = 6 * int'(predictor.cfg.dead_y) + 6;
               track_x = clamp_raw(track_x + $urandom_range(2 * reach_x) - reach_x);
               track_y = clamp_raw(track_y + $urandom_range(2 * reach_y) - reach_y);
            end
            // key bits 1..0 clear fall through to finger handling, unless all keys are clear while one is held
            keys = ($urandom_range(9) == 0) ? {6'($urandom), 2'b00} : 8'd0;
            send_request(REQ_REPORT, keys, 8'($urandom_range(255, 1)), 12'(track_x),
                         12'(track_y));
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = REQ_REPORT;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_DEAD_X;
      csr_data   = '0;
      track_x    = 2048;
      track_y    = 2048;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: deadband 15, spans 1814 / 3024, pen-up after 100 ticks
      send_request(REQ_TICK, 8'h00, 8'h00, 12'd0, 12'd0);        // not armed, nothing
      send_request(REQ_REPORT, 8'h00, 8'h00, 12'd0, 12'd0);      // no key held, no finger
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd0, 12'd0);      // first point, widest
      send_request(REQ_REPORT, 8'h00, 8'hff, 12'd10, 12'd10);    // inside deadband
      send_request(REQ_REPORT, 8'h00, 8'h80, 12'hfff, 12'hfff);  // above span: zero
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd1814, 12'd3024); // exactly span
      send_request(REQ_REPORT, 8'h02, 8'h00, 12'd0, 12'd0);      // menu down
      send_request(REQ_REPORT, 8'h01, 8'h00, 12'd0, 12'd0);      // back over menu
      send_request(REQ_REPORT, 8'h04, 8'h01, 12'd100, 12'd0);    // held, falls through
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd0, 12'd0);      // back released
      send_request(REQ_REPORT, 8'h03, 8'h00, 12'd0, 12'd0);      // menu wins over back
      send_request(REQ_REPORT, 8'hff, 8'hff, 12'hfff, 12'hfff);  // menu again
      send_request(REQ_REPORT, 8'h00, 8'hff, 12'd0, 12'd0);      // menu released
      send_request(REQ_TICK, 8'hff, 8'hff, 12'hfff, 12'hfff);    // countdown runs
      settle();

      // zero deadband, countdown of one; junk in the upper byte is masked off
      write_csr(CSR_DEAD_X, 16'hab00);
      write_csr(CSR_DEAD_Y, 16'h0000);
      write_csr(CSR_PENUP_TICKS, 16'd1);
      write_csr(CSR_PENUP_TICKS + 3'd1, 16'hffff);
      end_csr();
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd2, 12'd3);
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd2, 12'd3);      // same point, reported
      send_request(REQ_TICK, 8'h00, 8'h00, 12'd0, 12'd0);        // release
      send_request(REQ_TICK, 8'h00, 8'h00, 12'd0, 12'd0);        // disarmed again
      settle();

      // widest deadband, zero and full spans, countdown of zero
      write_csr(CSR_DEAD_X, 16'hffff);
      write_csr(CSR_DEAD_Y, 16'hffff);
      write_csr(CSR_SPAN_X, 16'h0000);
      write_csr(CSR_SPAN_Y, 16'hffff);
      write_csr(CSR_PENUP_TICKS, 16'd0);
      write_csr(CSR_PENUP_TICKS + 3'd3, 16'h5a5a);
      end_csr();
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd0, 12'd0);      // y at its maximum
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'hfff, 12'hfff);
      send_request(REQ_REPORT, 8'h00, 8'h01, 12'd0, 12'hff0);    // small move
      send_request(REQ_TICK, 8'h00, 8'h00, 12'd0, 12'd0);        // release
      send_request(REQ_TICK, 8'h00, 8'h00, 12'd0, 12'd0);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         program_phase();
         // two phases in a row without any gaps
         steady = (phase == 5 || phase == 6);
         run_phase(PHASE_ITEMS);
         settle();
      end
      steady = 1'b0;

      if (predictor.failures == 0 && predictor.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
